@@ sv/bdp_pkg.sv @@
// Shared types and codes for the binary delta patch applier.
// No dependencies; imported by the store and the top level.
package bdp_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_LOAD    = 3'd0;
	localparam op_t OP_CONTROL = 3'd1;
	localparam op_t OP_DIFF    = 3'd2;
	localparam op_t OP_EXTRA   = 3'd3;
	localparam op_t OP_FINISH  = 3'd4;

	localparam status_t ST_BYTE     = 2'd0;
	localparam status_t ST_ACCEPTED = 2'd1;
	localparam status_t ST_DONE     = 2'd2;
	localparam status_t ST_CORRUPT  = 2'd3;

	localparam logic CFG_NEW_SIZE = 1'b0;
	localparam logic CFG_OLD_SIZE = 1'b1;

endpackage

@@ sv/bdp_store.sv @@
// Old image byte store: one write port, one registered read port.
// Depends on bdp_pkg for the byte type.
module bdp_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bdp_pkg::byte_t  wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output bdp_pkg::byte_t  rdata
);
	import bdp_pkg::*;

	byte_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low, so a stalled beat keeps its byte
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/binary_delta_patch_apply_top.sv @@
// Binary delta patch applier: old store, control counters, two-stage result path.
// A result beat goes from the store read and stage 1, both loaded at the accepting edge,
// to the output register, which takes it when that register is empty or the sink is ready.
// Throughput: one item per cycle while the sink keeps taking results, set by the single read port of the old store.
// Reset (arst_n low) clears counters, positions, corrupt flag, size and valid registers;
// stage data registers and the old store are not cleared, and the store holds garbage until loaded.
// Depends on bdp_pkg and bdp_store.
module binary_delta_patch_apply_top #(
	parameter int OLD_DEPTH = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [30:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [15:0] load_address, [23:16] data_byte, [55:24] add_length,
	// [87:56] extra_length, [119:88] seek_offset
	input  logic [119:0] s_axis_tdata,
	// [2:0] operation
	input  bdp_pkg::op_t s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] out_byte, [38:8] out_index, [39] zero
	output logic [39:0]  m_axis_tdata,
	// [1:0] status
	output bdp_pkg::status_t m_axis_tuser
);
	import bdp_pkg::*;

	localparam int AW    = $clog2(OLD_DEPTH);
	localparam int LIM_W = AW + 1;

	// configuration
	logic [30:0] new_size_q;
	logic [16:0] old_size_q;

	// control state
	logic [30:0] new_pos_q, new_pos_d;
	logic [63:0] old_pos_q, old_pos_d;
	logic [30:0] diff_rem_q, diff_rem_d;
	logic [30:0] extra_rem_q, extra_rem_d;
	logic [30:0] pend_extra_q, pend_extra_d;
	logic [31:0] pend_seek_q, pend_seek_d;
	logic        corrupt_q, corrupt_d;

	// pipeline
	logic        valid_s1;
	status_t     st_s1;
	byte_t       dat_s1;
	logic [30:0] idx_s1;
	logic        use_s1;
	logic        out_valid_q;
	status_t     out_st_q;
	byte_t       out_byte_q;
	logic [30:0] out_idx_q;

	// input fields
	logic [15:0] ld_addr;
	byte_t       data_byte;
	logic [31:0] add_len, extra_len, seek_off;

	logic        acc, adv_s1;
	logic        mem_we, mem_re;
	byte_t       rd_data;
	logic [LIM_W-1:0] limit;
	logic        in_range;
	logic [33:0] end_sum;
	logic        ctl_bad;
	status_t     st_d;
	byte_t       dat_d;
	logic [30:0] idx_d;
	logic        use_d;

	assign ld_addr   = s_axis_tdata[15:0];
	assign data_byte = s_axis_tdata[23:16];
	assign add_len   = s_axis_tdata[55:24];
	assign extra_len = s_axis_tdata[87:56];
	assign seek_off  = s_axis_tdata[119:88];

	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (32'(old_size_q) < 32'(OLD_DEPTH)) begin
			limit = LIM_W'(old_size_q);
		end else begin
			limit = LIM_W'(OLD_DEPTH);
		end
	end
	assign in_range = old_pos_q < 64'(limit);

	// end of the new run after the triple; lengths are only used when non-negative
	assign end_sum = 34'(new_pos_q) + 34'(add_len[30:0]) + 34'(extra_len[30:0]);
	assign ctl_bad = (diff_rem_q != '0) || (extra_rem_q != '0) || add_len[31] ||
		extra_len[31] || (end_sum > 34'(new_size_q));

	assign mem_we = acc && (s_axis_tuser == OP_LOAD) && (32'(ld_addr) < 32'(OLD_DEPTH));
	assign mem_re = acc;

	bdp_store #(
		.DEPTH (OLD_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(ld_addr)),
		.wdata (data_byte),
		.re    (mem_re),
		.raddr (AW'(old_pos_q)),
		.rdata (rd_data)
	);

	always_comb begin
		new_pos_d    = new_pos_q;
		old_pos_d    = old_pos_q;
		diff_rem_d   = diff_rem_q;
		extra_rem_d  = extra_rem_q;
		pend_extra_d = pend_extra_q;
		pend_seek_d  = pend_seek_q;
		corrupt_d    = corrupt_q;
		st_d         = ST_ACCEPTED;
		dat_d        = '0;
		idx_d        = '0;
		use_d        = 1'b0;
		case (s_axis_tuser)
			OP_LOAD: begin
				st_d = ST_ACCEPTED;
			end
			OP_FINISH: begin
				if (!corrupt_q && diff_rem_q == '0 && extra_rem_q == '0 &&
					new_pos_q == new_size_q) begin
					st_d = ST_DONE;
				end else begin
					st_d = ST_CORRUPT;
				end
			end
			OP_CONTROL: begin
				if (corrupt_q) begin
					st_d = ST_CORRUPT;
				end else if (ctl_bad) begin
					corrupt_d = 1'b1;
					st_d      = ST_CORRUPT;
				end else begin
					diff_rem_d = add_len[30:0];
					if (add_len[30:0] == '0) begin
						// no diff bytes: extra run and seek take effect now
						old_pos_d    = old_pos_q + {{32{seek_off[31]}}, seek_off};
						extra_rem_d  = extra_len[30:0];
						pend_extra_d = '0;
						pend_seek_d  = '0;
					end else begin
						pend_extra_d = extra_len[30:0];
						pend_seek_d  = seek_off;
					end
				end
			end
			OP_DIFF: begin
				if (corrupt_q) begin
					st_d = ST_CORRUPT;
				end else if (diff_rem_q == '0) begin
					corrupt_d = 1'b1;
					st_d      = ST_CORRUPT;
				end else begin
					st_d       = ST_BYTE;
					dat_d      = data_byte;
					idx_d      = new_pos_q;
					use_d      = in_range;
					new_pos_d  = new_pos_q + 31'd1;
					diff_rem_d = diff_rem_q - 31'd1;
					if (diff_rem_q == 31'd1) begin
						old_pos_d    = old_pos_q + {{32{pend_seek_q[31]}}, pend_seek_q} +
							64'd1;
						extra_rem_d  = pend_extra_q;
						pend_extra_d = '0;
						pend_seek_d  = '0;
					end else begin
						old_pos_d = old_pos_q + 64'd1;
					end
				end
			end
			OP_EXTRA: begin
				if (corrupt_q) begin
					st_d = ST_CORRUPT;
				end else if (extra_rem_q == '0 || diff_rem_q != '0) begin
					corrupt_d = 1'b1;
					st_d      = ST_CORRUPT;
				end else begin
					st_d        = ST_BYTE;
					dat_d       = data_byte;
					idx_d       = new_pos_q;
					new_pos_d   = new_pos_q + 31'd1;
					extra_rem_d = extra_rem_q - 31'd1;
				end
			end
			default: begin
				st_d = ST_ACCEPTED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_size_q <= '0;
			old_size_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NEW_SIZE: new_size_q <= cfg_data;
				CFG_OLD_SIZE: old_size_q <= cfg_data[16:0];
				default:      new_size_q <= new_size_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_pos_q    <= '0;
			old_pos_q    <= '0;
			diff_rem_q   <= '0;
			extra_rem_q  <= '0;
			pend_extra_q <= '0;
			pend_seek_q  <= '0;
			corrupt_q    <= 1'b0;
		end else if (acc) begin
			new_pos_q    <= new_pos_d;
			old_pos_q    <= old_pos_d;
			diff_rem_q   <= diff_rem_d;
			extra_rem_q  <= extra_rem_d;
			pend_extra_q <= pend_extra_d;
			pend_seek_q  <= pend_seek_d;
			corrupt_q    <= corrupt_d;
		end
	end

	// stage 1: waits for the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			st_s1  <= st_d;
			dat_s1 <= dat_d;
			idx_s1 <= idx_d;
			use_s1 <= use_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_st_q   <= st_s1;
			out_byte_q <= use_s1 ? byte_t'(dat_s1 + rd_data) : dat_s1;
			out_idx_q  <= idx_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_st_q;
	assign m_axis_tdata  = {1'b0, out_idx_q, out_byte_q};

	// both stages full and the sink stalled: no new beat may enter
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("beat accepted with both stages full");

	a_corrupt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(corrupt_q))
		else $error("corrupt flag cleared outside reset");

	a_phase_order: assert property (@(posedge clk) disable iff (!arst_n)
		(diff_rem_q != '0) |-> (extra_rem_q == '0))
		else $error("extra run active during diff run");

	a_byte_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && st_d == ST_BYTE) |=> (new_pos_q == $past(new_pos_q) + 31'd1))
		else $error("new position did not advance on an emitted byte");

endmodule
